/* sv/rspl_pkg.sv */
// Package for the ranked species probability list.
// Types, field widths and operation codes shared by the cell and the top level.
// No dependencies.
package rspl_pkg;

   localparam int CODE_W  = 32;
   localparam int PROB_W  = 16;
   localparam int TOTAL_W = 22;
   localparam int MODE_W  = 3;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   // 1.0 in the probability fixed-point format
   localparam logic [TOTAL_W-1:0] ONE_FIXED = TOTAL_W'(32768);

   // Request operation codes
   localparam logic [MODE_W-1:0] MODE_ADD         = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD_PRIMARY = 3'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_SLOT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   // Contents of one list entry, also what a cell hands to its neighbor
   typedef struct packed {
      logic signed [CODE_W-1:0] species;
      logic [PROB_W-1:0]        prob;
      logic                     primary;
   } cell_data_type;

   // Operation broadcast to every cell
   typedef struct packed {
      logic clear;
      logic do_insert;
      logic do_update;
      logic set_primary;
      logic first_entry;
   } cell_ctl_type;

   // Request held between acceptance and the result register
   typedef struct packed {
      logic                     clear;
      logic                     is_query;
      logic                     add_en;
      logic                     sub_en;
      logic                     full;
      logic                     oob;
      logic [PROB_W-1:0]        new_prob;
      logic [PROB_W-1:0]        hit_prob;
      logic signed [CODE_W-1:0] slot_species;
      logic [PROB_W-1:0]        slot_prob;
   } pend_type;

endpackage

/* sv/rspl_cell.sv */
// One entry of the ranked species list: code, probability and primary mark.
// Compares against the broadcast request and shifts from its upper neighbor.
// Depends on rspl_pkg.
module rspl_cell
   import rspl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid,
   input  logic signed [CODE_W-1:0] code,
   input  logic [PROB_W-1:0]        prob,
   input  cell_ctl_type             ctl,
   input  logic                     prefix_in,
   output logic                     prefix_out,
   input  cell_data_type            nb,
   output cell_data_type            data,
   output logic                     hit
);

   logic signed [CODE_W-1:0] species_ff, species_in;
   logic [PROB_W-1:0]        prob_ff, prob_in;
   logic                     primary_ff, primary_in;
   logic                     gt;
   logic                     ins_here;
   logic                     shift;

   // Local compares; prefix_in is high while every entry above is greater
   assign hit        = valid && (species_ff == code);
   assign gt         = valid && (prob_ff > prob);
   assign prefix_out = prefix_in && gt;
   assign ins_here   = prefix_in && !gt;
   assign shift      = !prefix_in;

   // Next entry contents
   always_comb begin
      species_in = species_ff;
      prob_in    = prob_ff;
      primary_in = primary_ff;
      priority if (ctl.clear) begin
         primary_in = 1'b0;
      end else if (ctl.do_insert) begin
         if (shift) begin
            species_in = nb.species;
            prob_in    = nb.prob;
            primary_in = ctl.set_primary ? 1'b0 : nb.primary;
         end else if (ins_here) begin
            species_in = code;
            prob_in    = prob;
            primary_in = ctl.first_entry || ctl.set_primary;
         end else if (ctl.set_primary) begin
            primary_in = 1'b0;
         end
      end else if (ctl.do_update) begin
         if (hit) begin
            prob_in = prob;
         end
         if (ctl.set_primary) begin
            primary_in = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      species_ff <= species_in;
      prob_ff    <= prob_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primary_ff <= 1'b0;
      end else begin
         primary_ff <= primary_in;
      end
   end

   assign data = '{species: species_ff, prob: prob_ff, primary: primary_ff};

endmodule

/* sv/ranked_species_probability_list_unit.sv */
// Ranked species probability list, top level: cell chain, count, running total,
// request control and result register. Depends on rspl_pkg and rspl_cell.
//
// Keeps up to LIST_DEPTH (species, probability) pairs in descending order in a
// chain of cells. At the accepting edge every cell compares against the request
// and shifts or loads in parallel; in the finish step that follows, the running
// total is updated and the result is registered. The block then takes the next
// request, so it does not accept a new request before the last one has finished;
// a result left waiting holds back the finish step of the following request.
// The total is kept as a running sum, so its width does not depend on the list
// depth. Reset needs no clearing pass.
module ranked_species_probability_list_unit
   import rspl_pkg::*;
#(
   parameter int LIST_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic signed [CODE_W-1:0] req_species_code,
   input  logic [PROB_W-1:0]        req_probability,
   input  logic [SLOT_W-1:0]        req_slot,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PROB_W-1:0]        rsp_query_probability,
   output logic signed [CODE_W-1:0] rsp_slot_species,
   output logic [PROB_W-1:0]        rsp_slot_probability,
   output logic signed [CODE_W-1:0] rsp_primary_species,
   output logic [SLOT_W-1:0]        rsp_primary_slot,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic [TOTAL_W-1:0]       rsp_total_probability,
   output logic                     rsp_over_unity,
   output logic                     rsp_table_full,
   output logic                     rsp_out_of_bounds
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   pend_type             pend_ff, pend_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]    q_prob_ff;
   logic signed [CODE_W-1:0] s_spec_ff;
   logic [PROB_W-1:0]    s_prob_ff;
   logic signed [CODE_W-1:0] p_spec_ff;
   logic [SLOT_W-1:0]    p_slot_ff;
   logic [COUNT_W-1:0]   count_out_ff;
   logic [TOTAL_W-1:0]   total_out_ff;
   logic                 over_ff, full_ff, oob_ff;

   logic                 accept;
   logic                 finish_load;
   logic                 is_add;
   logic                 any_hit;
   logic                 list_full;
   logic                 insert_ok;
   logic                 update_ok;
   logic                 dropped;
   cell_ctl_type         ctl;

   logic [LIST_DEPTH:0]     prefix;
   cell_data_type           cdata [LIST_DEPTH];
   cell_data_type           nb    [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]   hit;
   logic [LIST_DEPTH-1:0]   valid;
   logic [LIST_DEPTH-1:0]   primary_vec;

   logic [PROB_W-1:0]        hit_prob;
   logic signed [CODE_W-1:0] slot_spec;
   logic [PROB_W-1:0]        slot_prob;
   logic signed [CODE_W-1:0] prim_spec;
   logic [IDX_W-1:0]         prim_idx;
   logic                     slot_oob;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Request decode against the current list
   assign is_add    = (req_mode == MODE_ADD) || (req_mode == MODE_ADD_PRIMARY);
   assign any_hit   = |hit;
   assign list_full = (count_ff == DEPTH_CNT);
   assign insert_ok = accept && is_add && !any_hit && !list_full;
   assign update_ok = accept && is_add && any_hit;
   assign dropped   = is_add && !any_hit && list_full;

   assign ctl = '{
      clear:       accept && (req_mode == MODE_CLEAR),
      do_insert:   insert_ok,
      do_update:   update_ok,
      set_primary: (req_mode == MODE_ADD_PRIMARY),
      first_entry: (count_ff == '0)
   };

   // Cell chain
   assign prefix[0] = 1'b1;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      assign valid[i]       = (count_ff > CNT_W'(i));
      assign primary_vec[i] = cdata[i].primary;
      if (i == 0) begin : g_head
         assign nb[i] = '0;
      end else begin : g_link
         assign nb[i] = cdata[i-1];
      end

      rspl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .valid      (valid[i]),
         .code       (req_species_code),
         .prob       (req_probability),
         .ctl        (ctl),
         .prefix_in  (prefix[i]),
         .prefix_out (prefix[i+1]),
         .nb         (nb[i]),
         .data       (cdata[i]),
         .hit        (hit[i])
      );
   end

   // Reads of the list as it stands at acceptance: hit probability and slot
   always_comb begin
      hit_prob  = '0;
      slot_spec = '0;
      slot_prob = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (hit[i]) begin
            hit_prob = hit_prob | cdata[i].prob;
         end
         if (valid[i] && (req_slot == SLOT_W'(i))) begin
            slot_spec = slot_spec | cdata[i].species;
            slot_prob = slot_prob | cdata[i].prob;
         end
      end
   end

   assign slot_oob = ({1'b0, req_slot} >= COUNT_W'(count_ff));

   // Primary entry after the update
   always_comb begin
      prim_spec = '0;
      prim_idx  = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (primary_vec[i]) begin
            prim_spec = prim_spec | cdata[i].species;
            prim_idx  = prim_idx | IDX_W'(i);
         end
      end
   end

   // Pending request fields and entry count
   always_comb begin
      pend_in              = pend_ff;
      count_in             = count_ff;
      if (accept) begin
         pend_in.clear        = ctl.clear;
         pend_in.is_query     = (req_mode == MODE_QUERY);
         pend_in.add_en       = insert_ok || update_ok;
         pend_in.sub_en       = update_ok;
         pend_in.full         = dropped;
         pend_in.oob          = (req_mode == MODE_READ_SLOT) && slot_oob;
         pend_in.new_prob     = req_probability;
         pend_in.hit_prob     = hit_prob;
         pend_in.slot_species = (req_mode == MODE_READ_SLOT) ? slot_spec : '0;
         pend_in.slot_prob    = (req_mode == MODE_READ_SLOT) ? slot_prob : '0;
         priority if (ctl.clear) begin
            count_in = '0;
         end else if (insert_ok) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Finish step: running total and result register
   assign finish_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (pend_ff.clear) begin
         total_in = '0;
      end else begin
         total_in = total_ff
                  + (pend_ff.add_en ? TOTAL_W'(pend_ff.new_prob) : '0)
                  - (pend_ff.sub_en ? TOTAL_W'(pend_ff.hit_prob) : '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_load) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (finish_load) begin
         q_prob_ff    <= pend_ff.is_query ? pend_ff.hit_prob : '0;
         s_spec_ff    <= pend_ff.slot_species;
         s_prob_ff    <= pend_ff.slot_prob;
         p_spec_ff    <= prim_spec;
         p_slot_ff    <= SLOT_W'(prim_idx);
         count_out_ff <= COUNT_W'(count_ff);
         total_out_ff <= total_in;
         over_ff      <= (total_in > ONE_FIXED);
         full_ff      <= pend_ff.full;
         oob_ff       <= pend_ff.oob;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_query_probability = q_prob_ff;
   assign rsp_slot_species      = s_spec_ff;
   assign rsp_slot_probability  = s_prob_ff;
   assign rsp_primary_species   = p_spec_ff;
   assign rsp_primary_slot      = p_slot_ff;
   assign rsp_entry_count       = count_out_ff;
   assign rsp_total_probability = total_out_ff;
   assign rsp_over_unity        = over_ff;
   assign rsp_table_full        = full_ff;
   assign rsp_out_of_bounds     = oob_ff;

   // Checks on the list state
   a_primary_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (primary_vec == '0))
      else $error("primary mark set in an empty list");

   a_primary_one: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> $onehot(primary_vec))
      else $error("non-empty list without exactly one primary entry");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond list depth");

   a_finish_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FINISH))
      else $error("accepted request did not enter finish step");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> $stable(count_ff))
      else $error("entry count changed outside acceptance");

endmodule

/* sim/testbench.sv */
// Testbench for ranked_species_probability_list_unit: directed and random requests
// checked against a behavioral model of the sorted list. Depends on rspl_pkg and the RTL.
`timescale 1ns / 1ps

module testbench
   import rspl_pkg::*;
();

   localparam int LIST_DEPTH      = 8;
   localparam int CODE_POOL_SIZE  = 14;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int MAX_ERROR_LINES = 50;

   // modes the block treats as no operation
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

   typedef struct {
      logic [PROB_W-1:0]  query_probability;
      logic [CODE_W-1:0]  slot_species;
      logic [PROB_W-1:0]  slot_probability;
      logic [CODE_W-1:0]  primary_species;
      logic [SLOT_W-1:0]  primary_slot;
      logic [COUNT_W-1:0] entry_count;
      logic [TOTAL_W-1:0] total_probability;
      logic               over_unity;
      logic               table_full;
      logic               out_of_bounds;
   } list_answer_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode = MODE_ADD;
   logic signed [CODE_W-1:0] req_species_code = '0;
   logic [PROB_W-1:0]        req_probability = '0;
   logic [SLOT_W-1:0]        req_slot = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [PROB_W-1:0]        rsp_query_probability;
   logic signed [CODE_W-1:0] rsp_slot_species;
   logic [PROB_W-1:0]        rsp_slot_probability;
   logic signed [CODE_W-1:0] rsp_primary_species;
   logic [SLOT_W-1:0]        rsp_primary_slot;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic [TOTAL_W-1:0]       rsp_total_probability;
   logic                     rsp_over_unity;
   logic                     rsp_table_full;
   logic                     rsp_out_of_bounds;

   // shadow copy of the list contents
   logic [CODE_W-1:0] shadow_species [LIST_DEPTH];
   logic [PROB_W-1:0] shadow_prob [LIST_DEPTH];
   int                shadow_count = 0;
   int                shadow_primary = 0;

   list_answer_type   answers_due[$];
   logic [CODE_W-1:0] code_pool [CODE_POOL_SIZE];
   int                error_count = 0;
   bit                send_idling = 1'b0;
   bit                rsp_idling = 1'b0;
   bit                hold_req = 1'b0;

   ranked_species_probability_list_unit #(.LIST_DEPTH(LIST_DEPTH)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- list model

   function automatic int shadow_find(logic [CODE_W-1:0] code);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_species[i] == code) return i;
      return -1;
   endfunction

   // add or update one code; returns 1 when a new code finds no room
   function automatic bit shadow_insert(logic [CODE_W-1:0] code, logic [PROB_W-1:0] prob);
      int hit;
      int pos;
      bit was_empty;
      hit = shadow_find(code);
      if (hit >= 0) begin
         shadow_prob[hit] = prob;
         return 1'b0;
      end
      if (shadow_count >= LIST_DEPTH) return 1'b1;
      was_empty = (shadow_count == 0);
      // new entry goes ahead of the first one not above it
      pos = 0;
      while (pos < shadow_count && shadow_prob[pos] > prob) pos++;
      for (int j = shadow_count; j > pos; j--) begin
         shadow_species[j] = shadow_species[j-1];
         shadow_prob[j]    = shadow_prob[j-1];
      end
      shadow_species[pos] = code;
      shadow_prob[pos]    = prob;
      shadow_count++;
      // primary follows its species
      if (was_empty) shadow_primary = 0;
      else if (pos <= shadow_primary) shadow_primary++;
      if (shadow_primary >= shadow_count) shadow_primary = 0;
      return 1'b0;
   endfunction

   // apply one accepted request and queue the answer it must produce
   function automatic void predict_list_step(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code,
                                             logic [PROB_W-1:0] prob, logic [SLOT_W-1:0] slot);
      list_answer_type ans;
      logic [TOTAL_W-1:0] sum;
      int hit;
      ans = '{default: '0};
      case (mode)
         MODE_ADD: ans.table_full = shadow_insert(code, prob);
         MODE_ADD_PRIMARY: begin
            ans.table_full = shadow_insert(code, prob);
            hit = shadow_find(code);
            if (hit >= 0) shadow_primary = hit;
         end
         MODE_QUERY: begin
            hit = shadow_find(code);
            if (hit >= 0) ans.query_probability = shadow_prob[hit];
         end
         MODE_READ_SLOT: begin
            if (slot < shadow_count) begin
               ans.slot_species     = shadow_species[slot];
               ans.slot_probability = shadow_prob[slot];
            end else begin
               ans.out_of_bounds = 1'b1;
            end
         end
         MODE_CLEAR: begin
            shadow_count   = 0;
            shadow_primary = 0;
         end
         default: ;
      endcase
      sum = '0;
      for (int i = 0; i < shadow_count; i++) sum += shadow_prob[i];
      if (shadow_count > 0 && shadow_primary < shadow_count)
         ans.primary_species = shadow_species[shadow_primary];
      ans.primary_slot      = SLOT_W'(shadow_primary);
      ans.entry_count       = COUNT_W'(shadow_count);
      ans.total_probability = sum;
      ans.over_unity        = (sum > ONE_FIXED);
      answers_due.push_back(ans);
   endfunction

   // ---------------------------------------------------------------- helpers

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_ERROR_LINES) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // drive one request and hold it until the block takes it
   task automatic send_request(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code,
                               logic [PROB_W-1:0] prob, logic [SLOT_W-1:0] slot);
      int gap;
      gap = (send_idling && $urandom_range(0, 1) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_species_code <= code;
      req_probability  <= prob;
      req_slot         <= slot;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_list_step(mode, code, prob, slot);
   endtask

   function automatic void refresh_code_pool();
      foreach (code_pool[i]) code_pool[i] = $urandom;
      code_pool[0] = '0;
      code_pool[1] = '1;
      code_pool[2] = 32'h8000_0000;
      code_pool[3] = 32'h7FFF_FFFF;
   endfunction

   function automatic logic [PROB_W-1:0] random_probability();
      case ($urandom_range(0, 7))
         0: return PROB_W'($urandom_range(0, 4) * 8192);   // ties
         1: return PROB_W'($urandom);                       // full field
         2: return PROB_W'(32768);
         default: return PROB_W'($urandom_range(0, 12000));
      endcase
   endfunction

   // codes mostly from a small pool so that hits and updates are common
   task automatic send_random_request();
      logic [MODE_W-1:0] mode;
      logic [CODE_W-1:0] code;
      logic [SLOT_W-1:0] slot;
      int r;
      r = $urandom_range(0, 99);
      if (r < 36)      mode = MODE_ADD;
      else if (r < 50) mode = MODE_ADD_PRIMARY;
      else if (r < 68) mode = MODE_QUERY;
      else if (r < 90) mode = MODE_READ_SLOT;
      else if (r < 96) mode = MODE_CLEAR;
      else if (r < 97) mode = MODE_SPARE_A;
      else if (r < 98) mode = MODE_SPARE_B;
      else             mode = MODE_SPARE_C;
      code = ($urandom_range(0, 9) == 0) ? $urandom
                                         : code_pool[$urandom_range(0, CODE_POOL_SIZE-1)];
      slot = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 63))
                                         : SLOT_W'($urandom_range(0, LIST_DEPTH+1));
      send_request(mode, code, random_probability(), slot);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_empty_list();
      send_request(MODE_READ_SLOT, '0, '0, '0);
      send_request(MODE_QUERY, '0, '0, '0);
      send_request(MODE_SPARE_A, 32'h1234_5678, 16'hFFFF, 6'h3F);
      send_request(MODE_CLEAR, '0, '0, '0);
   endtask

   // ordering on ties, primary tracking, in-place update, over unity
   task automatic test_insert_order();
      send_request(MODE_ADD, 32'h7FFF_FFFF, 16'd16384, '0);
      send_request(MODE_ADD, 32'd1, 16'd16384, '0);
      send_request(MODE_ADD_PRIMARY, 32'h8000_0000, 16'd0, '0);
      send_request(MODE_ADD, 32'd2, 16'd1, '0);
      send_request(MODE_ADD, 32'd1, 16'hFFFF, '0);
      send_request(MODE_QUERY, 32'd1, '0, '0);
      send_request(MODE_QUERY, 32'hFFFF_FFFF, '0, '0);
   endtask

   // drops when full, updates still allowed, reads past the end
   task automatic test_full_list();
      send_request(MODE_ADD, 32'd3, 16'd32768, '0);
      send_request(MODE_ADD, 32'd4, 16'd100, '0);
      send_request(MODE_ADD, 32'd5, 16'd200, '0);
      send_request(MODE_ADD, 32'd6, 16'd300, '0);
      send_request(MODE_ADD, 32'd7, 16'd500, '0);
      send_request(MODE_ADD_PRIMARY, 32'd8, 16'd0, '0);
      send_request(MODE_ADD, 32'd3, 16'd7, '0);
      send_request(MODE_ADD_PRIMARY, 32'd1, 16'd0, '0);
      send_request(MODE_READ_SLOT, '0, '0, 6'd7);
      send_request(MODE_READ_SLOT, '0, '0, 6'd8);
      send_request(MODE_READ_SLOT, '0, '0, 6'd63);
   endtask

   task automatic test_clear();
      send_request(MODE_SPARE_B, 32'd1, 16'd9, 6'd1);
      send_request(MODE_SPARE_C, 32'd2, 16'd9, 6'd2);
      send_request(MODE_CLEAR, '0, '0, '0);
      send_request(MODE_READ_SLOT, '0, '0, '0);
      send_request(MODE_QUERY, 32'd1, '0, '0);
   endtask

   task automatic test_random_traffic(int count, bit sender_gaps, bit receiver_gaps);
      send_idling = sender_gaps;
      rsp_idling  = receiver_gaps;
      refresh_code_pool();
      repeat (count) send_random_request();
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_backpressure(int count);
      send_idling = 1'b0;
      rsp_idling  = 1'b0;
      hold_req    = 1'b1;
      repeat (count) send_random_request();
   endtask

   // ---------------------------------------------------------------- processes

   // result ready: steady, random gaps, or one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (idle_length()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   // inputs change only at rising edges, so the falling edge sees settled values
   always @(negedge clock) begin
      list_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = answers_due.pop_front();
            check_field("query_probability", rsp_query_probability, want.query_probability);
            check_field("slot_species", rsp_slot_species, want.slot_species);
            check_field("slot_probability", rsp_slot_probability, want.slot_probability);
            check_field("primary_species", rsp_primary_species, want.primary_species);
            check_field("primary_slot", rsp_primary_slot, want.primary_slot);
            check_field("entry_count", rsp_entry_count, want.entry_count);
            check_field("total_probability", rsp_total_probability, want.total_probability);
            check_field("over_unity", rsp_over_unity, want.over_unity);
            check_field("table_full", rsp_table_full, want.table_full);
            check_field("out_of_bounds", rsp_out_of_bounds, want.out_of_bounds);
         end
      end
   end

   // stop a hung run
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("ERROR at %0t: no request or result moved for %0d cycles", $time, quiet);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_insert_order();
      test_full_list();
      test_clear();
      test_random_traffic(400, 1'b0, 1'b0);
      test_random_traffic(900, 1'b1, 1'b1);
      test_backpressure(40);
      test_random_traffic(400, 1'b1, 1'b0);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
